// ----- rtl/hlsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hlsc_pkg
// Shared types and constants for the hostname suffix classifier.
// ----------------------------------------------------------------------------
package hlsc_pkg;

    localparam int RULES_DEF        = 256;
    localparam int SUFFIX_CHARS_DEF = 127;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef enum logic [1:0]
    {
        FN_CLEAR = 2'd0,
        FN_APPEND = 2'd1,
        FN_CLOSE = 2'd2,
        FN_HOST = 2'd3
    } func_t;

    typedef struct packed
    {
        logic [1:0] func;
        logic [7:0] char_byte;
        logic       last;
        logic [7:0] category_id;
        logic [9:0] app_id;
    } in_item_t;

    typedef struct packed
    {
        logic       matched;
        logic [7:0] found_category;
        logic [9:0] found_app;
        logic [6:0] match_length;
        logic       table_overflow;
    } out_item_t;

    // Fold ASCII upper case to lower case.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/hlsc_ram.sv -----
// ----------------------------------------------------------------------------
// hlsc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module hlsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

// ----- rtl/hlsc_cell.sv -----
// ----------------------------------------------------------------------------
// hlsc_cell
// One window cell: holds one hostname character, shifts toward the tail.
// Also compares its character against the rule character broadcast for it.
// ----------------------------------------------------------------------------
module hlsc_cell
    import hlsc_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] char_in,
    output logic [7:0] char_out,
    input  logic [7:0] rule_char,
    output logic       eq
);

    logic [7:0] char_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            char_reg <= char_in;
        end
    end

    assign char_out = char_reg;
    assign eq       = (fold(char_reg) == fold(rule_char));

endmodule

// ----- rtl/hostname_longest_suffix_classifier.sv -----
// ----------------------------------------------------------------------------
// hostname_longest_suffix_classifier
// Longest domain-suffix match over a rule table against a hostname window.
// ----------------------------------------------------------------------------
// Table writes and hostname characters are taken while the block is idle.
// A final hostname character starts a scan: per rule, S_HDR and S_HDRW read
// and check its length, then S_CHR and S_CHRW compare its characters in turn;
// S_DONE rereads the winner's ids, if any, and fills an output register.
// Input waits during a scan; a finished scan waits while a result is pending.
// Reset clears rule count, window fill and overflow flag; RAMs are not cleared.
// ----------------------------------------------------------------------------
module hostname_longest_suffix_classifier
    import hlsc_pkg::*;
#(
    parameter int RULES        = RULES_DEF,
    parameter int SUFFIX_CHARS = SUFFIX_CHARS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int WINDOW = SUFFIX_CHARS + 1;
    localparam int RW  = $clog2(RULES);
    localparam int CW  = $clog2(SUFFIX_CHARS + 2);
    localparam int CAW = $clog2(RULES * SUFFIX_CHARS);
    localparam int KW  = $clog2(WINDOW);

    typedef enum logic [2:0]
    {
        S_IDLE, S_HDR, S_HDRW, S_CHR, S_CHRW, S_NEXT, S_DONE
    } state_t;

    state_t state_reg;
    logic [RW:0] rule_count_reg;
    logic [CW-1:0] build_len_reg;
    logic [CW-1:0] host_len_reg;
    logic overflow_reg;
    logic [RW:0] scan_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] top_len_reg;
    logic [RW-1:0] best_reg;
    logic found_reg;
    logic [CW-1:0] cur_len_reg;
    logic [CAW-1:0] base_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    logic acc;
    assign in_ready = (state_reg == S_IDLE);
    assign acc = in_valid && in_ready;

    // window chain of cells; cell 0 holds the newest character
    logic [7:0] cell_q [WINDOW];
    logic       cell_eq [WINDOW];
    logic [7:0] rc_bus;
    logic shift;
    assign shift = acc && (in_data.func == FN_HOST);

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        hlsc_cell u_cell (
            .clk(clk), .shift(shift),
            .char_in((i == 0) ? in_data.char_byte : cell_q[(i == 0) ? 0 : i - 1]),
            .char_out(cell_q[i]), .rule_char(rc_bus), .eq(cell_eq[i])
        );
    end

    // memories
    logic cw_we, hw_we;
    logic [CAW-1:0] c_addr;
    logic [7:0] c_rd;
    logic [RW-1:0] h_addr;
    logic [CW-1:0] len_rd;
    logic [7:0] cat_rd;
    logic [9:0] app_rd;
    logic [CAW-1:0] wr_caddr;

    assign wr_caddr = CAW'(rule_count_reg[RW-1:0] * SUFFIX_CHARS) + CAW'(build_len_reg);
    assign cw_we = acc && in_data.func == FN_APPEND && build_len_reg < CW'(SUFFIX_CHARS)
                   && rule_count_reg < (RW+1)'(RULES);
    assign hw_we = acc && in_data.func == FN_CLOSE && build_len_reg <= CW'(SUFFIX_CHARS)
                   && build_len_reg != '0 && rule_count_reg < (RW+1)'(RULES);
    // rule chars stored in order, read reversed at len-1-k
    assign c_addr = (state_reg == S_IDLE) ? wr_caddr
                  : base_reg + CAW'(cur_len_reg - CW'(1) - k_reg);
    assign h_addr = (state_reg == S_IDLE) ? rule_count_reg[RW-1:0] : scan_reg[RW-1:0];
    assign rc_bus = c_rd;

    hlsc_ram #(.WIDTH(8), .DEPTH(RULES * SUFFIX_CHARS)) u_chars (
        .clk(clk), .we(cw_we), .addr(c_addr), .wdata(in_data.char_byte), .rdata(c_rd));
    hlsc_ram #(.WIDTH(CW), .DEPTH(RULES)) u_len (
        .clk(clk), .we(hw_we), .addr(h_addr), .wdata(build_len_reg), .rdata(len_rd));
    hlsc_ram #(.WIDTH(8), .DEPTH(RULES)) u_cat (
        .clk(clk), .we(hw_we), .addr(h_addr), .wdata(in_data.category_id), .rdata(cat_rd));
    hlsc_ram #(.WIDTH(10), .DEPTH(RULES)) u_app (
        .clk(clk), .we(hw_we), .addr(h_addr), .wdata(in_data.app_id), .rdata(app_rd));

    // cell select for compare and dot check
    logic sel_eq;
    logic [7:0] dot_q;
    assign sel_eq = cell_eq[k_reg[KW-1:0]];
    assign dot_q  = cell_q[cur_len_reg[$clog2(WINDOW)-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rule_count_reg <= '0;
            build_len_reg  <= '0;
            host_len_reg   <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            top_len_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        case (in_data.func)
                            FN_CLEAR:
                            begin
                                rule_count_reg <= '0;
                                build_len_reg  <= '0;
                                overflow_reg   <= 1'b0;
                            end
                            FN_APPEND:
                            begin
                                if (build_len_reg < CW'(SUFFIX_CHARS))
                                    build_len_reg <= build_len_reg + CW'(1);
                                else
                                    build_len_reg <= CW'(SUFFIX_CHARS + 1);
                            end
                            FN_CLOSE:
                            begin
                                if (build_len_reg > CW'(SUFFIX_CHARS) || (build_len_reg != '0
                                    && rule_count_reg >= (RW+1)'(RULES)))
                                    overflow_reg <= 1'b1;
                                else if (build_len_reg != '0)
                                    rule_count_reg <= rule_count_reg + (RW+1)'(1);
                                build_len_reg <= '0;
                            end
                            default:
                            begin
                                if (host_len_reg < CW'(WINDOW))
                                    host_len_reg <= host_len_reg + CW'(1);
                                if (in_data.last)
                                begin
                                    scan_reg     <= '0;
                                    found_reg    <= 1'b0;
                                    top_len_reg  <= '0;
                                    state_reg    <= S_NEXT;
                                end
                            end
                        endcase
                    end
                end
                S_NEXT:
                begin
                    if (scan_reg >= rule_count_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_HDR;
                end
                S_HDR:
                    state_reg <= S_HDRW;
                S_HDRW:
                begin
                    cur_len_reg <= len_rd;
                    base_reg <= CAW'(scan_reg[RW-1:0] * SUFFIX_CHARS);
                    k_reg <= '0;
                    if (len_rd <= top_len_reg || len_rd > host_len_reg)
                    begin
                        scan_reg  <= scan_reg + (RW+1)'(1);
                        state_reg <= S_NEXT;
                    end
                    else
                        state_reg <= S_CHR;
                end
                S_CHR:
                    state_reg <= S_CHRW;
                S_CHRW:
                begin
                    if (!sel_eq)
                    begin
                        scan_reg  <= scan_reg + (RW+1)'(1);
                        state_reg <= S_NEXT;
                    end
                    else if (k_reg + CW'(1) == cur_len_reg)
                    begin
                        if (host_len_reg == cur_len_reg || dot_q == DOT_CHAR)
                        begin
                            found_reg    <= 1'b1;
                            top_len_reg  <= cur_len_reg;
                            best_reg     <= scan_reg[RW-1:0];
                        end
                        scan_reg  <= scan_reg + (RW+1)'(1);
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_CHR;
                    end
                end
                S_DONE:
                begin
                    // reread winner's ids if found, then wait for a free output register
                    if (!found_reg || k_reg == CW'(2))
                    begin
                        if (!out_valid_reg || out_ready)
                        begin
                            out_reg.matched        <= found_reg;
                            out_reg.found_category <= found_reg ? cat_rd : 8'd0;
                            out_reg.found_app      <= found_reg ? app_rd : 10'd0;
                            out_reg.match_length   <= 7'(top_len_reg);
                            out_reg.table_overflow <= overflow_reg;
                            out_valid_reg <= 1'b1;
                            host_len_reg  <= '0;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        scan_reg <= {1'b0, best_reg};
                        k_reg    <= (k_reg == CW'(1)) ? CW'(2) : CW'(1);
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/hlsc_checker.sv -----
// ----------------------------------------------------------------------------
// hlsc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module hlsc_checker
    import hlsc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.matched |-> out_data.match_length == 7'd0
        && out_data.found_app == 10'd0 && out_data.found_category == 8'd0)
        else $error("unmatched result carries ids");

    a_matched_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched |-> out_data.match_length != 7'd0)
        else $error("match with zero length");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result carries unknown bits");

endmodule

bind hostname_longest_suffix_classifier hlsc_checker u_hlsc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives rule-table writes and hostname characters into the suffix classifier
// and checks every lookup result against an in-bench model of the table.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hlsc_pkg::*;

    localparam int NRULES  = RULES_DEF;
    localparam int MAXLEN  = SUFFIX_CHARS_DEF;
    localparam int WIN     = MAXLEN + 1;
    localparam int IDLE_LIMIT = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    hostname_longest_suffix_classifier u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Model state
    logic [7:0] tbl_chars [NRULES][MAXLEN];
    int         tbl_len [NRULES];
    logic [7:0] tbl_cat [NRULES];
    logic [9:0] tbl_app [NRULES];
    int         n_rules;
    int         build_len;
    logic [7:0] host_win [WIN];
    int         host_len;
    int         host_wp;
    logic       ovf;

    out_item_t  lookups_pending [$];
    int         errors;
    int         idle_cycles;
    bit         hold_off;
    bit         done;

    // Directed stimulus table; fixed results only where trivially known
    typedef struct
    {
        in_item_t  item;
        bit        has_fixed;
        out_item_t fixed;
    } row_t;
    row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic [7:0] lc(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] host_at(input int k);
        return host_win[(host_wp + WIN - 1 - (k % WIN)) % WIN];
    endfunction

    // Apply one accepted item to the model; push a lookup result if any
    task automatic classify_step(input in_item_t it);
        int         top_len;
        int         best;
        bit         ok;
        out_item_t  res;
        case (func_t'(it.func))
            FN_CLEAR:
            begin
                n_rules = 0;
                build_len = 0;
                ovf = 1'b0;
            end
            FN_APPEND:
            begin
                if (build_len < MAXLEN)
                begin
                    if (n_rules < NRULES)
                        tbl_chars[n_rules][build_len] = it.char_byte;
                    build_len++;
                end
                else
                    build_len = MAXLEN + 1;
            end
            FN_CLOSE:
            begin
                if (build_len > MAXLEN || (build_len > 0 && n_rules >= NRULES))
                    ovf = 1'b1;
                else if (build_len > 0)
                begin
                    tbl_len[n_rules] = build_len;
                    tbl_cat[n_rules] = it.category_id;
                    tbl_app[n_rules] = it.app_id;
                    n_rules++;
                end
                build_len = 0;
            end
            default:
            begin
                host_win[host_wp] = it.char_byte;
                host_wp = (host_wp + 1) % WIN;
                if (host_len < WIN)
                    host_len++;
                if (it.last)
                begin
                    top_len = 0;
                    best = 0;
                    for (int r = 0; r < n_rules; r++)
                    begin
                        ok = tbl_len[r] > 0 && tbl_len[r] <= host_len;
                        for (int k = 0; ok && k < tbl_len[r]; k++)
                            if (lc(tbl_chars[r][tbl_len[r] - 1 - k]) != lc(host_at(k)))
                                ok = 0;
                        if (ok && host_len != tbl_len[r])
                            ok = host_at(tbl_len[r]) == DOT_CHAR;
                        if (ok && tbl_len[r] > top_len)
                        begin
                            top_len = tbl_len[r];
                            best = r;
                        end
                    end
                    res.matched        = top_len > 0;
                    res.found_category = top_len > 0 ? tbl_cat[best] : 8'd0;
                    res.found_app      = top_len > 0 ? tbl_app[best] : 10'd0;
                    res.match_length   = top_len[6:0];
                    res.table_overflow = ovf;
                    lookups_pending.push_back(res);
                    host_len = 0;
                end
            end
        endcase
    endtask

    function automatic in_item_t mk(input func_t f, input logic [7:0] c, input logic l,
                                    input logic [7:0] cat, input logic [9:0] app);
        in_item_t it;
        it.func = f;
        it.char_byte = c;
        it.last = l;
        it.category_id = cat;
        it.app_id = app;
        return it;
    endfunction

    // Send one item, with a random gap when a burst ends
    int burst_left;
    task automatic send_item(input in_item_t it);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        classify_step(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_rule(input string s, input logic [7:0] cat, input logic [9:0] app);
        for (int i = 0; i < s.len(); i++)
            send_item(mk(FN_APPEND, s[i], 0, 0, 0));
        send_item(mk(FN_CLOSE, 0, 0, cat, app));
    endtask

    task automatic send_host(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(mk(FN_HOST, s[i], i == s.len() - 1, $urandom, $urandom));
    endtask

    // Random label of letters and dots, with some odd bytes
    function automatic string rand_word(input int n);
        string s;
        byte   c;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: c = 8'h2E;
                1: c = $urandom_range(0, 255);
                2, 3: c = $urandom_range(8'h41, 8'h43);
                default: c = $urandom_range(8'h61, 8'h63);
            endcase
            s = {s, string'(c)};
        end
        return s;
    endfunction

    // Receiver stall pattern, plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (($urandom_range(0, 99) < 30) && ($time / 20000) % 2 == 0)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Check results as they come out
    always @(posedge clk)
    begin
        out_item_t ex;
        if (rst_n && out_valid && out_ready)
        begin
            if (lookups_pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                ex = lookups_pending.pop_front();
                if (out_data.matched !== ex.matched ||
                    out_data.found_category !== ex.found_category ||
                    out_data.found_app !== ex.found_app ||
                    out_data.match_length !== ex.match_length ||
                    out_data.table_overflow !== ex.table_overflow)
                begin
                    $display("%0t: expected %p actual %p", $time, ex, out_data);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        row_t      rw;
        int        sent;
        int        nlen;
        string     rs;
        out_item_t zero_res;
        errors = 0;
        idle_cycles = 0;
        hold_off = 0;
        burst_left = 0;
        n_rules = 0;
        build_len = 0;
        host_len = 0;
        host_wp = 0;
        ovf = 0;
        for (int i = 0; i < WIN; i++)
            host_win[i] = 8'h00;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: empty table lookup, extremes, case folding, dot boundary
        zero_res = '0;
        rw.has_fixed = 1; rw.fixed = zero_res;
        rw.item = mk(FN_HOST, 8'hFF, 1, 8'hFF, 10'h3FF); dir_rows.push_back(rw);
        rw.has_fixed = 0;
        rw.item = mk(FN_CLOSE, 0, 0, 8'hFF, 10'h3FF); dir_rows.push_back(rw);
        rw.item = mk(FN_APPEND, 8'h00, 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_APPEND, 8'hFF, 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_CLOSE, 0, 0, 8'hFF, 10'h3FF); dir_rows.push_back(rw);
        rw.item = mk(FN_APPEND, "c", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_APPEND, "O", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_CLOSE, 0, 0, 8'h00, 10'h000); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, "a", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, ".", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, "C", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, "o", 1, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, "x", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, "c", 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, "o", 1, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, 8'h00, 0, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_HOST, 8'hFF, 1, 0, 0); dir_rows.push_back(rw);
        rw.item = mk(FN_CLEAR, 0, 0, 0, 0); dir_rows.push_back(rw);
        rw.has_fixed = 1;
        rw.item = mk(FN_HOST, "o", 1, 0, 0); dir_rows.push_back(rw);
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].item);
            if (dir_rows[i].has_fixed)
                if (lookups_pending[$] !== dir_rows[i].fixed)
                begin
                    $display("%0t: expected %p actual %p", $time, dir_rows[i].fixed,
                             lookups_pending[$]);
                    errors++;
                end
        end

        // Over-long rule, then a full-length rule and a full-window hostname
        for (int i = 0; i < MAXLEN + 2; i++)
            send_item(mk(FN_APPEND, "b", 0, 0, 0));
        send_item(mk(FN_CLOSE, 0, 0, 1, 1));
        rs = "";
        for (int i = 0; i < MAXLEN; i++)
            rs = {rs, "b"};
        send_rule(rs, 8'h5A, 10'h2A5);
        send_host({"bbb", rs});

        // Long hold-off while the sender keeps pushing lookups
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 40; i++)
                send_host("b");
        join

        // Fill the table past capacity with short rules
        send_item(mk(FN_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < NRULES + 2; i++)
            send_rule(rand_word($urandom_range(1, 3)), $urandom, $urandom);
        send_host(rand_word(4));

        // Random phases: small tables of related rules, hostnames built from them
        sent = 0;
        while (sent < 800)
        begin
            string rules [$];
            send_item(mk(FN_CLEAR, 0, 0, 0, 0));
            rules.delete();
            repeat ($urandom_range(1, 8))
            begin
                rs = rand_word($urandom_range(1, 5));
                if (rules.size() > 0 && $urandom_range(0, 1))
                    rs = {rs, rules[$urandom_range(0, rules.size() - 1)]};
                rules.push_back(rs);
                send_rule(rs, $urandom, $urandom);
                sent += rs.len() + 1;
            end
            repeat ($urandom_range(3, 10))
            begin
                case ($urandom_range(0, 9))
                    0: send_item(mk(func_t'($urandom_range(1, 2)), $urandom, $urandom,
                                    $urandom, $urandom));
                    1, 2: rs = rand_word($urandom_range(1, 12));
                    default:
                    begin
                        rs = rules[$urandom_range(0, rules.size() - 1)];
                        if ($urandom_range(0, 1))
                            rs = {rand_word($urandom_range(1, 4)), ".", rs};
                    end
                endcase
                send_host(rs);
                sent += rs.len() + 1;
            end
        end

        // Drain
        while (lookups_pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- hostname_longest_suffix_classifier.f -----
rtl/hlsc_pkg.sv
rtl/hlsc_ram.sv
rtl/hlsc_cell.sv
rtl/hostname_longest_suffix_classifier.sv
rtl/hlsc_checker.sv
tb/testbench.sv
